// ----- rtl/kji_pkg.sv -----
package kji_pkg;

	localparam int JOINT_W = 5;
	localparam int JC_W    = 6;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_START = 2'd1;
	localparam func_t FUNC_TICK  = 2'd2;

endpackage

// ----- rtl/keyframe_joint_interpolator.sv -----
// Channel  Handshake              Payload
// -------  ---------------------  -----------------------------------------
// in       in_valid / in_ready    func, joint, angle, steps
// out      out_valid / out_ready  out_joint, out_angle, last, segment_end
// cfg      cfg_valid / cfg_ready  cfg_data (joint_count)
//
// A load or a start leaves the block idle. A tick sends one result per joint;
// each joint is read, then passes through the bit-serial scale-and-divide step
// that every joint shares, which is skipped once the segment has reached its end.
// Reset clears every bank entry through per-entry valid bits, so no sweep.
// A stalled output holds the current result and the next joint waits for it.
module keyframe_joint_interpolator #(
	parameter int MAX_JOINTS = 32,
	parameter int ANGLE_BITS = 16,
	parameter int STEP_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kji_pkg::func_t                func,
	input  logic [kji_pkg::JOINT_W-1:0]   joint,
	input  logic signed [ANGLE_BITS-1:0]  angle,
	input  logic [STEP_BITS-1:0]          steps,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kji_pkg::JOINT_W-1:0]   out_joint,
	output logic signed [ANGLE_BITS-1:0]  out_angle,
	output logic                          last,
	output logic                          segment_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kji_pkg::JC_W-1:0]      cfg_data
);
	import kji_pkg::*;

	localparam int DEPTH = 3 * MAX_JOINTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int NW    = $clog2(MAX_JOINTS + 1);
	localparam int BCW   = $clog2(ANGLE_BITS + 1);
	localparam int TW    = STEP_BITS + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD_A = 3'd1;
	localparam logic [2:0] ST_RD_B = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;

	logic [2:0]              state_q;
	logic [1:0]              sel_start_q, sel_tgt_q, sel_pend_q;
	logic [STEP_BITS-1:0]    steps_q, cnt_q;
	logic [JC_W-1:0]         jc_q;
	logic [NW-1:0]           n_q;
	logic [JW-1:0]           j_q;
	logic                    at_end_q;
	logic [BCW-1:0]          bits_q;

	logic [ANGLE_BITS-1:0]   mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic [ANGLE_BITS-1:0]   rd_q;
	logic                    rd_vld_q;
	logic [ANGLE_BITS-1:0]   rd_val;

	logic [ANGLE_BITS-1:0]   a_q, mag_q, quo_q, res_q;
	logic [STEP_BITS-1:0]    rem_q;
	logic                    neg_q;

	logic                    in_xfer, out_free, out_push, mem_we;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic [6:0]              n_full;
	logic                    is_last;
	logic [ANGLE_BITS:0]     diff;
	logic [TW-1:0]           t_val, t_n, t_2n;
	logic [1:0]              q_inc;
	logic [TW-1:0]           t_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	assign out_push  = (state_q == ST_PUSH) && out_free;

	assign mem_we  = in_xfer && (func == FUNC_LOAD) && (7'(joint) < 7'(MAX_JOINTS));
	assign wr_addr = AW'(sel_pend_q) * AW'(MAX_JOINTS) + AW'(joint);
	assign rd_addr = (state_q == ST_RD_A) ? AW'(sel_start_q) * AW'(MAX_JOINTS) + AW'(j_q)
	                                      : AW'(sel_tgt_q) * AW'(MAX_JOINTS) + AW'(j_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= angle;
		rd_q     <= mem[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
	end

	assign rd_val = rd_vld_q ? rd_q : '0;

	// clamp the joint count into 1 .. MAX_JOINTS
	always_comb begin
		if (jc_q == '0)
			n_full = 7'd1;
		else if (7'(jc_q) > 7'(MAX_JOINTS))
			n_full = 7'(MAX_JOINTS);
		else
			n_full = 7'(jc_q);
	end

	assign is_last = (NW'(j_q) + NW'(1)) == n_q;
	assign diff    = {rd_val[ANGLE_BITS-1], rd_val} - {a_q[ANGLE_BITS-1], a_q};

	// one step of mag*cnt/steps: adds 0, 1 or 2 to the shifted quotient; remainder stays below steps
	always_comb begin
		t_val = {1'b0, rem_q, 1'b0} + (mag_q[ANGLE_BITS-1] ? TW'(cnt_q) : '0);
		t_n   = TW'(steps_q);
		t_2n  = TW'({steps_q, 1'b0});
		if (t_val >= t_2n) begin
			q_inc  = 2'd2;
			t_next = t_val - t_2n;
		end else if (t_val >= t_n) begin
			q_inc  = 2'd1;
			t_next = t_val - t_n;
		end else begin
			q_inc  = 2'd0;
			t_next = t_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_start_q <= 2'd0;
			sel_tgt_q   <= 2'd1;
			sel_pend_q  <= 2'd2;
			steps_q     <= '0;
			cnt_q       <= '0;
			jc_q        <= JC_W'(1);
			vld_q       <= '0;
			out_valid   <= 1'b0;
			n_q         <= '0;
			j_q         <= '0;
			at_end_q    <= 1'b0;
			bits_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				jc_q <= cfg_data;
			if (mem_we)
				vld_q[wr_addr] <= 1'b1;
			if (out_push)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (func)
							FUNC_START: begin
								sel_start_q <= sel_tgt_q;
								sel_tgt_q   <= sel_pend_q;
								sel_pend_q  <= sel_start_q;
								steps_q     <= steps;
								cnt_q       <= '0;
							end
							FUNC_TICK: begin
								n_q      <= NW'(n_full);
								j_q      <= '0;
								at_end_q <= (steps_q == '0) || (cnt_q >= steps_q);
								state_q  <= ST_RD_A;
							end
							default: ;
						endcase
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_INIT;
				ST_INIT: begin
					bits_q  <= BCW'(ANGLE_BITS);
					state_q <= at_end_q ? ST_PUSH : ST_DIV;
				end
				ST_DIV: begin
					bits_q <= bits_q - BCW'(1);
					if (bits_q == BCW'(1))
						state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (out_free) begin
						if (is_last) begin
							if (cnt_q < steps_q)
								cnt_q <= cnt_q + STEP_BITS'(1);
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + JW'(1);
							state_q <= ST_RD_A;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD_B: a_q <= rd_val;
			ST_INIT: begin
				neg_q <= diff[ANGLE_BITS];
				mag_q <= diff[ANGLE_BITS] ? ANGLE_BITS'(-diff) : diff[ANGLE_BITS-1:0];
				rem_q <= '0;
				quo_q <= '0;
				res_q <= rd_val;
			end
			ST_DIV: begin
				mag_q <= {mag_q[ANGLE_BITS-2:0], 1'b0};
				rem_q <= t_next[STEP_BITS-1:0];
				quo_q <= {quo_q[ANGLE_BITS-2:0], 1'b0} + ANGLE_BITS'(q_inc);
			end
			ST_SUM: res_q <= neg_q ? a_q - quo_q : a_q + quo_q;
			ST_PUSH: begin
				if (out_free) begin
					out_joint   <= JOINT_W'(j_q);
					out_angle   <= res_q;
					last        <= is_last;
					segment_end <= at_end_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/kji_check.sv -----
module kji_check #(
	parameter int ANGLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input kji_pkg::func_t                func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [kji_pkg::JOINT_W-1:0]   out_joint,
	input logic signed [ANGLE_BITS-1:0]  out_angle,
	input logic                          last,
	input logic                          segment_end
);
	import kji_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_joint)
			&& $stable(last) && $stable(segment_end))
		else $error("stalled result changed");

	// a tick keeps the input closed until its snapshot is under way
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_TICK |=> !in_ready)
		else $error("input open right after a tick transfer");

	// a snapshot still in flight keeps the input closed
	a_mid_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input open in the middle of a snapshot");

	// a load completes in its own cycle
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_LOAD |=> in_ready)
		else $error("load did not complete in one cycle");

endmodule

bind keyframe_joint_interpolator kji_check #(
	.ANGLE_BITS(ANGLE_BITS)
) u_kji_check (.*);
